// File: rtl/pendulum_com_trajectory_core_assert.svh
// assertion macros for the pendulum com trajectory core
// expects clk and arst_n in the scope of each use
`ifndef PENDULUM_COM_TRAJECTORY_CORE_ASSERT_SVH
`define PENDULUM_COM_TRAJECTORY_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PCT_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pct: same-cycle check failed");
`define PCT_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pct: next-cycle check failed");
`else
`define PCT_ASSERT_IMP(lbl, pre, post)
`define PCT_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// File: rtl/pct_pkg.sv
// shared types, constants and helpers of the pendulum com trajectory core
// no dependencies
`timescale 1ns / 1ps
package pct_pkg;

	localparam int DATA_W      = 32;
	localparam int DIFF_W      = DATA_W + 1;
	localparam int GAIN_W      = 24;
	localparam int TSTEP_W     = 17;
	localparam int NPHASE_W    = 6;
	localparam int CFG_DATA_W  = 32;
	localparam int PADDR_W     = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam int DEF_MAX_PHASE_TICKS = 32;
	localparam int DEF_FRAC_BITS       = 16;

	localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(8036);
	localparam logic [TSTEP_W-1:0]  TSTEP_RST  = TSTEP_W'(655);
	localparam logic [NPHASE_W-1:0] NPHASE_RST = NPHASE_W'(32);

	typedef enum logic [1:0] {
		REG_GAIN   = 2'd0,
		REG_TSTEP  = 2'd1,
		REG_NPHASE = 2'd2
	} pct_reg_t;

	typedef enum logic {
		CMD_INIT = 1'b0,
		CMD_MOVE = 1'b1
	} pct_cmd_t;

	typedef struct packed {
		pct_cmd_t                 kind;
		logic                     fin;
		logic signed [DATA_W-1:0] from_x;
		logic signed [DATA_W-1:0] from_y;
		logic signed [DATA_W-1:0] to_x;
		logic signed [DATA_W-1:0] to_y;
	} pct_entry_t;

	typedef struct packed {
		logic emit;
		logic phase_end;
	} pct_bstat_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) begin
			return hi[DATA_W-1:0];
		end else if (v < lo) begin
			return lo[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

// File: rtl/pct_queue.sv
// short command queue between front and back
// depends on pct_pkg
`timescale 1ns / 1ps
module pct_queue import pct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  pct_entry_t in_entry,
	output logic       out_valid,
	input  logic       out_ready,
	output pct_entry_t out_entry
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pct_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_entry = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				mem_q[i] <= '0;
			end
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				mem_q[wr_q] <= in_entry;
				wr_q        <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/pct_front.sv
// front end: takes footsteps and turns each into one command for the back end
// depends on pct_pkg
`timescale 1ns / 1ps
module pct_front import pct_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*DATA_W-1:0] s_tdata,   // foot_x, foot_y
	input  logic                s_tlast,   // final_step
	output logic                q_valid,
	input  logic                q_ready,
	output pct_entry_t          q_entry
);

	logic                     started_q;
	logic signed [DATA_W-1:0] prev_x_q;
	logic signed [DATA_W-1:0] prev_y_q;
	logic                     accept;

	assign s_tready = q_ready;
	assign q_valid  = s_tvalid;
	assign accept   = s_tvalid && q_ready;

	always_comb begin
		q_entry.kind   = started_q ? CMD_MOVE : CMD_INIT;
		q_entry.fin    = s_tlast;
		q_entry.from_x = prev_x_q;
		q_entry.from_y = prev_y_q;
		q_entry.to_x   = s_tdata[DATA_W-1:0];
		q_entry.to_y   = s_tdata[2*DATA_W-1:DATA_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
		end else if (accept) begin
			// a final footstep closes the plan
			started_q <= !s_tlast;
			prev_x_q  <= s_tdata[DATA_W-1:0];
			prev_y_q  <= s_tdata[2*DATA_W-1:DATA_W];
		end
	end

endmodule

// File: rtl/pct_div.sv
// bit-serial floor division of a signed footstep distance by the phase length
// one quotient bit per cycle; depends on pct_pkg
`timescale 1ns / 1ps
module pct_div import pct_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIFF_W-1:0] dvd,
	input  logic [NPHASE_W-1:0]      dvs,
	output logic                     done,
	output logic signed [DIFF_W-1:0] quo,
	output logic [NPHASE_W-1:0]      rem
);

	localparam int MAG_W = DIFF_W - 1;
	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0]    mag_q;
	logic [MAG_W-1:0]    quo_q;
	logic [NPHASE_W-1:0] acc_q;
	logic [NPHASE_W-1:0] dvs_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic                busy_q;
	logic                done_q;

	logic [DIFF_W-1:0]   absd;
	logic [NPHASE_W:0]   trial;
	logic [NPHASE_W:0]   trial_sub;
	logic                ge;

	assign absd      = dvd[DIFF_W-1] ? DIFF_W'(-dvd) : DIFF_W'(dvd);
	assign trial     = {acc_q, mag_q[MAG_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign ge        = trial >= {1'b0, dvs_q};

	// floor correction for a negative distance
	always_comb begin
		if (neg_q && acc_q != '0) begin
			quo = ~$signed({1'b0, quo_q});
			rem = dvs_q - acc_q;
		end else if (neg_q) begin
			quo = -$signed({1'b0, quo_q});
			rem = acc_q;
		end else begin
			quo = $signed({1'b0, quo_q});
			rem = acc_q;
		end
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q  <= '0;
			quo_q  <= '0;
			acc_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			mag_q  <= absd[MAG_W-1:0];
			quo_q  <= '0;
			acc_q  <= '0;
			dvs_q  <= dvs;
			cnt_q  <= CNT_W'(MAG_W);
			neg_q  <= dvd[DIFF_W-1];
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			acc_q <= ge ? trial_sub[NPHASE_W-1:0] : trial[NPHASE_W-1:0];
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
			quo_q <= {quo_q[MAG_W-2:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// File: rtl/pct_back.sv
// back end: runs footstep commands as phases of pendulum integration ticks
// depends on pct_pkg and pct_div
`timescale 1ns / 1ps
module pct_back import pct_pkg::*; #(
	parameter int MAX_PHASE_TICKS = DEF_MAX_PHASE_TICKS,
	parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [GAIN_W-1:0]   gain,
	input  logic [TSTEP_W-1:0]  tstep,
	input  logic [NPHASE_W-1:0] nphase,
	input  logic                q_valid,
	output logic                q_ready,
	input  pct_entry_t          q_entry,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [2*DATA_W-1:0] m_tdata,   // com_x, com_y
	output logic                m_tlast,   // run_end
	output pct_bstat_t          stat
);

	localparam int CNT_W  = $clog2(MAX_PHASE_TICKS + 1);
	localparam int P1_W   = GAIN_W + 1 + DIFF_W;
	localparam int P2_W   = DATA_W + TSTEP_W + 1;
	localparam int WIDE_W = 64;
	localparam int ZS_W   = DIFF_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_ERR,
		S_MUL1,
		S_VEL,
		S_MUL2,
		S_POS
	} state_t;

	state_t                   state_q;
	logic signed [DATA_W-1:0] pos_q [2];
	logic signed [DATA_W-1:0] vel_q [2];
	logic signed [DATA_W-1:0] zq_q  [2];
	logic signed [DATA_W-1:0] to_q  [2];
	logic signed [DIFF_W-1:0] q0_q  [2];
	logic signed [DIFF_W-1:0] err_q [2];
	logic [NPHASE_W-1:0]      r0_q  [2];
	logic [NPHASE_W-1:0]      zr_q  [2];
	logic signed [P1_W-1:0]   p1_q  [2];
	logic signed [P2_W-1:0]   p2_q  [2];
	logic [CNT_W-1:0]         len_q;
	logic [CNT_W-1:0]         s_q;
	logic                     mark_q;
	logic                     fin_q;
	logic                     hold_q;
	logic [2*DATA_W-1:0]      tdata_q;
	logic                     tvalid_q;
	logic                     tlast_q;

	logic signed [DATA_W-1:0] from_v  [2];
	logic signed [DATA_W-1:0] to_v    [2];
	logic signed [DIFF_W-1:0] diff_v  [2];
	logic signed [DIFF_W-1:0] dquo    [2];
	logic [NPHASE_W-1:0]      drem    [2];
	logic                     ddone   [2];
	logic signed [P1_W-1:0]   dv      [2];
	logic signed [P2_W-1:0]   dp      [2];
	logic signed [WIDE_W-1:0] vsum    [2];
	logic signed [WIDE_W-1:0] psum    [2];
	logic signed [DATA_W-1:0] vel_new [2];
	logic signed [DATA_W-1:0] pos_new [2];
	logic [NPHASE_W:0]        zr_sum  [2];
	logic                     zinc    [2];
	logic [ZS_W-1:0]          zsum    [2];
	logic [CNT_W-1:0]         len_c;
	logic                     pop;
	logic                     div_go;
	logic                     last_tick;
	logic                     emit;

	assign from_v[0] = q_entry.from_x;
	assign from_v[1] = q_entry.from_y;
	assign to_v[0]   = q_entry.to_x;
	assign to_v[1]   = q_entry.to_y;

	always_comb begin
		if (nphase == '0) begin
			len_c = CNT_W'(1);
		end else if (nphase > NPHASE_W'(MAX_PHASE_TICKS)) begin
			len_c = CNT_W'(MAX_PHASE_TICKS);
		end else begin
			len_c = CNT_W'(nphase);
		end
	end

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			diff_v[a]  = {to_v[a][DATA_W-1], to_v[a]} - {from_v[a][DATA_W-1], from_v[a]};
			dv[a]      = p1_q[a] >>> FRAC_BITS;
			vsum[a]    = {{(WIDE_W-DATA_W){vel_q[a][DATA_W-1]}}, vel_q[a]}
			           + {{(WIDE_W-P1_W){dv[a][P1_W-1]}}, dv[a]};
			vel_new[a] = sat32(vsum[a]);
			dp[a]      = p2_q[a] >>> FRAC_BITS;
			psum[a]    = {{(WIDE_W-DATA_W){pos_q[a][DATA_W-1]}}, pos_q[a]}
			           + {{(WIDE_W-P2_W){dp[a][P2_W-1]}}, dp[a]};
			pos_new[a] = sat32(psum[a]);
			// zmp walks by q0 each tick, plus one when the remainder wraps
			zr_sum[a]  = {1'b0, zr_q[a]} + {1'b0, r0_q[a]};
			zinc[a]    = zr_sum[a] >= (NPHASE_W+1)'(len_q);
			zsum[a]    = {{(ZS_W-DATA_W){zq_q[a][DATA_W-1]}}, zq_q[a]}
			           + {q0_q[a][DIFF_W-1], q0_q[a]} + ZS_W'(zinc[a]);
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_div
		pct_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_go),
			.dvd    (diff_v[a]),
			.dvs    (NPHASE_W'(len_c)),
			.done   (ddone[a]),
			.quo    (dquo[a]),
			.rem    (drem[a])
		);
	end

	assign q_ready   = state_q == S_IDLE;
	assign pop       = q_valid && q_ready;
	assign div_go    = pop && q_entry.kind == CMD_MOVE;
	assign last_tick = (s_q + CNT_W'(1)) == len_q;
	assign emit      = state_q == S_POS && (!tvalid_q || m_tready);

	assign m_tvalid       = tvalid_q;
	assign m_tdata        = tdata_q;
	assign m_tlast        = tlast_q;
	assign stat.emit      = emit;
	assign stat.phase_end = emit && last_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			for (int a = 0; a < 2; a++) begin
				pos_q[a] <= '0;
				vel_q[a] <= '0;
				zq_q[a]  <= '0;
				to_q[a]  <= '0;
				q0_q[a]  <= '0;
				err_q[a] <= '0;
				r0_q[a]  <= '0;
				zr_q[a]  <= '0;
				p1_q[a]  <= '0;
				p2_q[a]  <= '0;
			end
			len_q    <= '0;
			s_q      <= '0;
			mark_q   <= 1'b0;
			fin_q    <= 1'b0;
			hold_q   <= 1'b0;
			tdata_q  <= '0;
			tvalid_q <= 1'b0;
			tlast_q  <= 1'b0;
		end else begin
			if (emit) begin
				tvalid_q <= 1'b1;
				tdata_q  <= {pos_new[1], pos_new[0]};
				tlast_q  <= last_tick && mark_q;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (pop) begin
						len_q <= len_c;
						s_q   <= '0;
						fin_q <= q_entry.fin;
						for (int a = 0; a < 2; a++) begin
							to_q[a] <= to_v[a];
							zr_q[a] <= '0;
						end
						if (q_entry.kind == CMD_INIT) begin
							for (int a = 0; a < 2; a++) begin
								pos_q[a] <= to_v[a];
								vel_q[a] <= '0;
								zq_q[a]  <= to_v[a];
								q0_q[a]  <= '0;
								r0_q[a]  <= '0;
							end
							mark_q  <= 1'b1;
							hold_q  <= 1'b1;
							state_q <= q_entry.fin ? S_ERR : S_IDLE;
						end else begin
							for (int a = 0; a < 2; a++) begin
								zq_q[a] <= from_v[a];
							end
							mark_q  <= !q_entry.fin;
							hold_q  <= 1'b0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (ddone[0] && ddone[1]) begin
						for (int a = 0; a < 2; a++) begin
							q0_q[a] <= dquo[a];
							r0_q[a] <= drem[a];
						end
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					for (int a = 0; a < 2; a++) begin
						err_q[a] <= {pos_q[a][DATA_W-1], pos_q[a]}
						          - {zq_q[a][DATA_W-1], zq_q[a]};
					end
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					for (int a = 0; a < 2; a++) begin
						p1_q[a] <= $signed({1'b0, gain}) * err_q[a];
					end
					state_q <= S_VEL;
				end
				S_VEL: begin
					for (int a = 0; a < 2; a++) begin
						vel_q[a] <= vel_new[a];
						zq_q[a]  <= zsum[a][DATA_W-1:0];
						zr_q[a]  <= zinc[a] ? NPHASE_W'(zr_sum[a] - (NPHASE_W+1)'(len_q))
						                    : zr_sum[a][NPHASE_W-1:0];
					end
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					for (int a = 0; a < 2; a++) begin
						p2_q[a] <= vel_q[a] * $signed({1'b0, tstep});
					end
					state_q <= S_POS;
				end
				S_POS: begin
					if (emit) begin
						for (int a = 0; a < 2; a++) begin
							pos_q[a] <= pos_new[a];
						end
						if (last_tick) begin
							if (!hold_q && fin_q) begin
								// holding phase on the final footstep
								for (int a = 0; a < 2; a++) begin
									zq_q[a] <= to_q[a];
									q0_q[a] <= '0;
									r0_q[a] <= '0;
									zr_q[a] <= '0;
								end
								s_q     <= '0;
								mark_q  <= 1'b1;
								hold_q  <= 1'b1;
								state_q <= S_ERR;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							s_q     <= s_q + CNT_W'(1);
							state_q <= S_ERR;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/pendulum_com_trajectory_core.sv
// pendulum com trajectory core: footsteps in, com samples out, apb registers
// path: an accepted footstep is registered in the queue, which the back end pops only when idle;
// a moving phase then waits on the serial division before its first com item is valid
// each tick runs the err, mul1, vel, mul2 and pos states, stalling in pos while the output is full
// a final footstep adds a holding phase; a first non-final one only loads the start position
// reset: asynchronous, registers return to defaults, plan restarts; no clearing pass
`timescale 1ns / 1ps
`include "pendulum_com_trajectory_core_assert.svh"
module pendulum_com_trajectory_core import pct_pkg::*; #(
	parameter int MAX_PHASE_TICKS = DEF_MAX_PHASE_TICKS,
	parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [2*DATA_W-1:0]   s_tdata,   // foot_x, foot_y
	input  logic                  s_tlast,   // final_step
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [2*DATA_W-1:0]   m_tdata,   // com_x, com_y
	output logic                  m_tlast,   // run_end
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [GAIN_W-1:0]   gain_q;
	logic [TSTEP_W-1:0]  tstep_q;
	logic [NPHASE_W-1:0] nphase_q;
	pct_reg_t            reg_idx;
	logic                cfg_wr;

	logic                q_in_valid;
	logic                q_in_ready;
	pct_entry_t          q_in_entry;
	logic                q_valid;
	logic                q_ready;
	pct_entry_t          q_entry;
	pct_bstat_t          bk_stat;

	assign pready  = 1'b1;
	assign reg_idx = pct_reg_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RST;
			tstep_q  <= TSTEP_RST;
			nphase_q <= NPHASE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
				REG_TSTEP:  tstep_q  <= pwdata[TSTEP_W-1:0];
				REG_NPHASE: nphase_q <= pwdata[NPHASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN:   prdata = CFG_DATA_W'(gain_q);
			REG_TSTEP:  prdata = CFG_DATA_W'(tstep_q);
			REG_NPHASE: prdata = CFG_DATA_W'(nphase_q);
			default:    prdata = '0;
		endcase
	end

	pct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (q_in_valid),
		.q_ready  (q_in_ready),
		.q_entry  (q_in_entry)
	);

	pct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_in_valid),
		.in_ready  (q_in_ready),
		.in_entry  (q_in_entry),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_entry (q_entry)
	);

	pct_back #(
		.MAX_PHASE_TICKS (MAX_PHASE_TICKS),
		.FRAC_BITS       (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain     (gain_q),
		.tstep    (tstep_q),
		.nphase   (nphase_q),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_entry  (q_entry),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.stat     (bk_stat)
	);

	`PCT_ASSERT_NXT(a_accept_queued, s_tvalid && s_tready, q_valid)
	`PCT_ASSERT_IMP(a_no_overwrite, m_tvalid && !m_tready, !bk_stat.emit)
	`PCT_ASSERT_NXT(a_mid_tick_out, bk_stat.emit && !bk_stat.phase_end, m_tvalid && !m_tlast)

endmodule

// File: tb/pendulum_com_trajectory_core_tb.sv
// testbench for pendulum_com_trajectory_core: footsteps in, com samples checked against
// a fixed-point pendulum predictor kept in step with the apb register writes
// depends on pct_pkg and the core rtl
`timescale 1ns / 1ps
module pendulum_com_trajectory_core_tb;
	import pct_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 80;
	localparam int MAX_TICKS     = DEF_MAX_PHASE_TICKS;
	localparam int FRAC          = DEF_FRAC_BITS;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [DATA_W-1:0] com_x;
		logic [DATA_W-1:0] com_y;
		logic              run_end;
	} com_sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [2*DATA_W-1:0]   s_tdata = '0;   // foot_x, foot_y
	logic                  s_tlast = 1'b0; // final_step
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [2*DATA_W-1:0]   m_tdata;        // com_x, com_y
	logic                  m_tlast;        // run_end
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	logic [GAIN_W-1:0]   gain_cfg   = GAIN_RST;
	logic [TSTEP_W-1:0]  tstep_cfg  = TSTEP_RST;
	logic [NPHASE_W-1:0] nphase_cfg = NPHASE_RST;

	longint com_px = 0, com_py = 0, com_vx = 0, com_vy = 0;
	longint last_foot_x = 0, last_foot_y = 0;
	bit     plan_open = 1'b0;

	com_sample_t com_expected[$];
	int mismatch_count = 0;
	int items_checked = 0;
	int footsteps_sent = 0;
	int cfg_writes = 0;
	int cycle_count = 0;
	bit no_idle = 1'b0;

	pendulum_com_trajectory_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(99) >= 29);
	end

	function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		if (mismatch_count < 10) begin
			$display("mismatch %s: expected %h, got %h", what, want, got);
		end
		mismatch_count++;
	endfunction

	function automatic longint clamp_q31(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b != 0) && ((a < 0) != (b < 0))) begin
			q -= 1;
		end
		return q;
	endfunction

	function automatic void integrate_axis(inout longint pos, inout longint vel,
			input longint zmp);
		longint dv;
		dv = (longint'(gain_cfg) * (pos - zmp)) >>> FRAC;
		vel = clamp_q31(vel + dv);
		pos = clamp_q31(pos + ((vel * longint'(tstep_cfg)) >>> FRAC));
	endfunction

	// one phase of ticks, zmp sliding from one footstep towards the next
	function automatic void predict_phase(longint from_x, longint from_y,
			longint to_x, longint to_y, bit mark_end);
		longint ticks;
		longint zx;
		longint zy;
		com_sample_t smp;
		ticks = longint'(nphase_cfg);
		if (ticks < 1) begin
			ticks = 1;
		end
		if (ticks > MAX_TICKS) begin
			ticks = MAX_TICKS;
		end
		for (longint s = 0; s < ticks; s++) begin
			zx = from_x + floor_quot((to_x - from_x) * s, ticks);
			zy = from_y + floor_quot((to_y - from_y) * s, ticks);
			integrate_axis(com_px, com_vx, zx);
			integrate_axis(com_py, com_vy, zy);
			smp.com_x = com_px[DATA_W-1:0];
			smp.com_y = com_py[DATA_W-1:0];
			smp.run_end = mark_end && (s == ticks - 1);
			com_expected = {com_expected, smp};
		end
	endfunction

	function automatic void predict_footstep(longint x, longint y, bit fin);
		if (!plan_open) begin
			com_px = x;
			com_py = y;
			com_vx = 0;
			com_vy = 0;
			plan_open = 1'b1;
		end else begin
			predict_phase(last_foot_x, last_foot_y, x, y, !fin);
		end
		last_foot_x = x;
		last_foot_y = y;
		if (fin) begin
			predict_phase(x, y, x, y, 1'b1);
			plan_open = 1'b0;
		end
	endfunction

	always @(posedge clk) begin
		com_sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (com_expected.size() == 0) begin
				note_mismatch("unexpected com item", '0, m_tdata);
			end else begin
				want = com_expected.pop_front();
				if (m_tdata[DATA_W-1:0] !== want.com_x) begin
					note_mismatch("com_x", 64'(want.com_x), 64'(m_tdata[DATA_W-1:0]));
				end
				if (m_tdata[2*DATA_W-1:DATA_W] !== want.com_y) begin
					note_mismatch("com_y", 64'(want.com_y),
						64'(m_tdata[2*DATA_W-1:DATA_W]));
				end
				if (m_tlast !== want.run_end) begin
					note_mismatch("run_end", 64'(want.run_end), 64'(m_tlast));
				end
				items_checked++;
			end
		end
	end

	task automatic send_footstep(input logic [DATA_W-1:0] fx, input logic [DATA_W-1:0] fy,
			input bit fin);
		while (!no_idle && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {fy, fx};
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		predict_footstep(longint'($signed(fx)), longint'($signed(fy)), fin);
		footsteps_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (com_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GAIN: gain_cfg = value[GAIN_W-1:0];
			REG_TSTEP: tstep_cfg = value[TSTEP_W-1:0];
			REG_NPHASE: nphase_cfg = value[NPHASE_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [1:0] idx, output logic [CFG_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_registers();
		logic [CFG_DATA_W-1:0] got;
		apb_read(REG_GAIN, got);
		if (got !== CFG_DATA_W'(gain_cfg)) begin
			note_mismatch("accel_gain readback", 64'(gain_cfg), 64'(got));
		end
		apb_read(REG_TSTEP, got);
		if (got !== CFG_DATA_W'(tstep_cfg)) begin
			note_mismatch("time_step readback", 64'(tstep_cfg), 64'(got));
		end
		apb_read(REG_NPHASE, got);
		if (got !== CFG_DATA_W'(nphase_cfg)) begin
			note_mismatch("phase length readback", 64'(nphase_cfg), 64'(got));
		end
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] tstep,
			input logic [CFG_DATA_W-1:0] nphase);
		wait_idle();
		apb_write(REG_GAIN, gain);
		apb_write(REG_TSTEP, tstep);
		apb_write(REG_NPHASE, nphase);
	endtask

	function automatic logic [DATA_W-1:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			2: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0000_0000;
				endcase
			end
			default: return $urandom_range(0, 8) * 32'h0001_0000;
		endcase
	endfunction

	// mostly whole plans walking in small strides, some stray footsteps in between
	task automatic send_random_plans(input int count);
		int sent;
		int plan_len;
		logic [DATA_W-1:0] wx;
		logic [DATA_W-1:0] wy;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) < 8) begin
				plan_len = $urandom_range(2, 5);
				wx = random_coord();
				wy = random_coord();
				for (int k = 0; k < plan_len; k++) begin
					send_footstep(wx, wy, k == plan_len - 1);
					if ($urandom_range(7) == 0) begin
						wx = random_coord();
						wy = random_coord();
					end else begin
						wx = wx + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
						wy = wy + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
					end
				end
				sent += plan_len;
			end else begin
				send_footstep(random_coord(), random_coord(), $urandom_range(1) == 1);
				sent++;
			end
		end
	endtask

	task automatic test_reset_defaults();
		check_registers();
		send_footstep(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_footstep(32'h0001_0000, 32'h0000_8000, 1'b0);
		send_footstep(32'h0002_0000, 32'h0000_0000, 1'b1);
	endtask

	task automatic test_register_access();
		wait_idle();
		apb_write(REG_GAIN, 32'hFFFF_FFFF);
		apb_write(REG_TSTEP, 32'hFFFF_FFFF);
		apb_write(REG_NPHASE, 32'hFFFF_FFFF);
		check_registers();
		apb_write(REG_UNUSED, 32'h0000_0001);
		check_registers();
	endtask

	task automatic test_field_extremes();
		configure(32'h00FF_FFFF, 32'h0001_0000, 32'd4);
		// a lone final footstep opens and closes a plan
		send_footstep(32'h0000_0000, 32'h0000_0000, 1'b1);
		send_footstep(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_footstep(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_footstep(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_footstep(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		configure(32'h0000_0000, 32'h0000_0001, 32'd3);
		send_footstep(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_footstep(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
	endtask

	task automatic test_phase_lengths();
		logic [CFG_DATA_W-1:0] lengths[4];
		lengths = '{32'd0, 32'd1, 32'd33, 32'd63};
		foreach (lengths[i]) begin
			configure(32'd8036, 32'd655, lengths[i]);
			send_footstep(random_coord(), random_coord(), 1'b0);
			send_footstep(random_coord(), random_coord(), 1'b1);
		end
	endtask

	task automatic test_zero_time_step();
		configure(32'h00FF_FFFF, 32'h0000_0000, 32'd5);
		send_footstep(32'h0003_0000, 32'hFFFF_0000, 1'b0);
		send_footstep(32'h0000_0000, 32'h0005_0000, 1'b1);
	endtask

	task automatic test_streaming_no_idle();
		configure(32'd8036, 32'd655, 32'd2);
		no_idle = 1'b1;
		send_random_plans(15);
		wait_idle();
		no_idle = 1'b0;
	endtask

	task automatic test_random_plans();
		configure(32'd8036, 32'd655, $urandom_range(2, 8));
		send_random_plans(20);
		configure($urandom_range(0, 32'h00FF_FFFF), $urandom_range(1, 32'h0001_0000),
			$urandom_range(1, 8));
		send_random_plans(20);
		configure($urandom_range(0, 20000), 32'h0001_FFFF, 32'd32);
		send_random_plans(8);
		configure(32'h00FF_FFFF, $urandom, $urandom_range(0, 63));
		send_random_plans(20);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_access();
		test_field_extremes();
		test_phase_lengths();
		test_zero_time_step();
		test_streaming_no_idle();
		test_random_plans();
		wait_idle();
		$display("covered %0d footsteps and %0d com items under %0d register writes",
			footsteps_sent, items_checked, cfg_writes);
		$display("incl. saturation, zero time step, phase lengths 0 to 63, back to back plans");
		if (mismatch_count == 0 && com_expected.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d com items never arrived",
				mismatch_count, com_expected.size());
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

endmodule
